// ----- hdl/mcmp_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI channel message parser package
// Shared types, constants and the data byte count lookup for the parser.
// ----------------------------------------------------------------------------
package mcmp_pkg;

  localparam int unsigned ByteWidth = 8;

  localparam logic [ByteWidth-1:0] SYSEX_START = 8'hF0;
  localparam logic [ByteWidth-1:0] SYSEX_END   = 8'hF7;

  localparam logic [3:0] NIB_NOTE_OFF  = 4'h8;
  localparam logic [3:0] NIB_NOTE_ON   = 4'h9;
  localparam logic [3:0] NIB_POLY_PRES = 4'hA;
  localparam logic [3:0] NIB_CONTROL   = 4'hB;
  localparam logic [3:0] NIB_PROGRAM   = 4'hC;
  localparam logic [3:0] NIB_CHAN_PRES = 4'hD;
  localparam logic [3:0] NIB_PITCH     = 4'hE;

  typedef logic [ByteWidth-1:0] byte_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_SYSEX   = 2'd1,
    MODE_COLLECT = 2'd2
  } parse_mode_t;

  typedef enum logic [1:0] {
    NEED_NONE = 2'd0,
    NEED_ONE  = 2'd1,
    NEED_TWO  = 2'd2
  } data_need_t;

  typedef struct packed {
    byte_t status;
    byte_t first;
    byte_t second;
  } message_t;

  typedef struct packed {
    logic     valid;
    byte_t    data_byte;
    logic     packet_end;
  } request_t;

  function automatic data_need_t data_bytes_needed(input byte_t status);
    data_need_t need;
    begin
      unique case (status[7:4])
        NIB_PROGRAM, NIB_CHAN_PRES: need = NEED_ONE;
        NIB_NOTE_OFF, NIB_NOTE_ON, NIB_POLY_PRES, NIB_CONTROL, NIB_PITCH: need = NEED_TWO;
        default: need = NEED_NONE;
      endcase
      return need;
    end
  endfunction

endpackage

// ----- hdl/mcmp_input_stage.sv -----
// ----------------------------------------------------------------------------
// MIDI parser input register
// Holds one accepted request until the parse step takes it.
// ----------------------------------------------------------------------------
module mcmp_input_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  mcmp_pkg::byte_t  data_byte,
  input  logic             packet_end,
  input  logic             advance,
  output mcmp_pkg::request_t req
);
  import mcmp_pkg::*;

  logic  held_valid;
  byte_t held_byte;
  logic  held_end;

  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= data_byte;
      held_end  <= packet_end;
    end
  end

  assign req = '{valid: held_valid, data_byte: held_byte, packet_end: held_end};

endmodule

// ----- hdl/mcmp_parse_step.sv -----
// ----------------------------------------------------------------------------
// MIDI parser step
// Parser state and the single-byte state update with message completion.
// ----------------------------------------------------------------------------
module mcmp_parse_step (
  input  logic                clk,
  input  logic                rst,
  input  mcmp_pkg::request_t  req,
  input  logic                advance,
  input  logic                deliver_enable,
  output logic                result_valid,
  output mcmp_pkg::message_t  result
);
  import mcmp_pkg::*;

  parse_mode_t mode, mode_next;
  byte_t       held_status, held_status_next;
  byte_t       held_first, held_first_next;
  logic        first_held, first_held_next;
  logic        done;
  data_need_t  need_held;
  data_need_t  need_in;

  assign need_held = data_bytes_needed(held_status);
  assign need_in   = data_bytes_needed(req.data_byte);

  always_comb begin
    done   = 1'b0;
    result = '{status: held_status, first: req.data_byte, second: '0};
    if (mode == MODE_COLLECT) begin
      if (need_held == NEED_ONE) begin
        done = 1'b1;
      end else if (first_held) begin
        done          = 1'b1;
        result.first  = held_first;
        result.second = req.data_byte;
      end
    end
  end

  always_comb begin
    mode_next        = mode;
    held_status_next = held_status;
    held_first_next  = held_first;
    first_held_next  = first_held;
    unique case (mode)
      MODE_SYSEX: begin
        if (req.data_byte == SYSEX_END) begin
          mode_next        = MODE_IDLE;
          held_status_next = '0;
          held_first_next  = '0;
          first_held_next  = 1'b0;
        end
      end
      MODE_COLLECT: begin
        if (done) begin
          mode_next        = MODE_IDLE;
          held_status_next = '0;
          held_first_next  = '0;
          first_held_next  = 1'b0;
        end else begin
          held_first_next = req.data_byte;
          first_held_next = 1'b1;
        end
      end
      default: begin
        held_first_next = '0;
        first_held_next = 1'b0;
        if (req.data_byte == SYSEX_START) begin
          mode_next        = MODE_SYSEX;
          held_status_next = '0;
        end else if (req.data_byte[7] && need_in != NEED_NONE) begin
          mode_next        = MODE_COLLECT;
          held_status_next = req.data_byte;
        end else begin
          mode_next        = MODE_IDLE;
          held_status_next = '0;
        end
      end
    endcase
    if (req.packet_end) begin
      mode_next        = MODE_IDLE;
      held_status_next = '0;
      held_first_next  = '0;
      first_held_next  = 1'b0;
    end
  end

  assign result_valid = req.valid && done && deliver_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_IDLE;
      held_status <= '0;
      held_first  <= '0;
      first_held  <= 1'b0;
    end else if (advance) begin
      mode        <= mode_next;
      held_status <= held_status_next;
      held_first  <= held_first_next;
      first_held  <= first_held_next;
    end
  end

endmodule

// ----- hdl/mcmp_output_stage.sv -----
// ----------------------------------------------------------------------------
// MIDI parser output register
// Holds one completed message until the downstream side takes it.
// ----------------------------------------------------------------------------
module mcmp_output_stage (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  mcmp_pkg::message_t msg,
  output logic               out_valid,
  input  logic               out_ready,
  output mcmp_pkg::byte_t    status_out,
  output mcmp_pkg::byte_t    first_data,
  output mcmp_pkg::byte_t    second_data
);
  import mcmp_pkg::*;

  message_t held_msg;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_msg <= msg;
    end
  end

  assign status_out  = held_msg.status;
  assign first_data  = held_msg.first;
  assign second_data = held_msg.second;

endmodule

// ----- hdl/midi_channel_message_parser.sv -----
// ----------------------------------------------------------------------------
// MIDI channel message parser
// A message's last byte is held in the input register; the completed message is then registered in the output register.
// Throughput: one byte per cycle, limited only by output back-pressure.
// Reset clears the parser to idle and disables delivery.
// ----------------------------------------------------------------------------
module midi_channel_message_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_write,
  input  logic            cfg_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  mcmp_pkg::byte_t data_byte,
  input  logic            packet_end,
  output logic            out_valid,
  input  logic            out_ready,
  output mcmp_pkg::byte_t status_out,
  output mcmp_pkg::byte_t first_data,
  output mcmp_pkg::byte_t second_data
);
  import mcmp_pkg::*;

  logic     deliver_enable;
  request_t req;
  logic     advance;
  logic     result_valid;
  message_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      deliver_enable <= 1'b0;
    end else if (cfg_write) begin
      deliver_enable <= cfg_data;
    end
  end

  // A request moves on unless it completes a message while the output is still full.
  assign advance = req.valid && (!result_valid || !out_valid || out_ready);

  mcmp_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .packet_end (packet_end),
    .advance    (advance),
    .req        (req)
  );

  mcmp_parse_step u_step (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .advance        (advance),
    .deliver_enable (deliver_enable),
    .result_valid   (result_valid),
    .result         (result)
  );

  mcmp_output_stage u_output (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && result_valid),
    .msg         (result),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status_out  (status_out),
    .first_data  (first_data),
    .second_data (second_data)
  );

endmodule
